// ----- src/integer_matrix_add_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// integer_matrix_add_multiply assertion macros
// Shared checker shorthands; the including module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_ADD_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_ADD_MULTIPLY_ASSERT_SVH

// consequent must hold in the same cycle
`define IMAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define IMAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/imam_pkg.sv -----
// ----------------------------------------------------------------------------
// imam_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package imam_pkg;

  localparam int MAX_DIM   = 8;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = DIM_W + 1;
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
  localparam logic [OP_W-1:0] OP_SUM  = 2'd2;
  localparam logic [OP_W-1:0] OP_PROD = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic              first;
    logic              last;
    logic              is_sum;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              push;
    logic              push_err;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic              fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/imam_dp.sv -----
// ----------------------------------------------------------------------------
// imam_dp
// Matrix stores, shared multiply/add unit, accumulator and output register.
// ----------------------------------------------------------------------------
`include "integer_matrix_add_multiply_assert.svh"

module imam_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [imam_pkg::DIM_W-1:0]    in_row_index,
  input  logic [imam_pkg::DIM_W-1:0]    in_col_index,
  input  logic signed [imam_pkg::DATA_W-1:0] in_element_value,
  input  imam_pkg::ctrl_cmd_t           cmd,
  output imam_pkg::dp_stat_t            stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [imam_pkg::DIM_W-1:0]    out_row,
  output logic [imam_pkg::DIM_W-1:0]    out_col,
  output logic signed [imam_pkg::DATA_W-1:0] out_result_value,
  output logic                          out_last,
  output logic                          out_dim_error
);
  import imam_pkg::*;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [ADDR_W-1:0] wr_addr;

  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic              v1_r, f1_r, l1_r, s1_r;
  logic              v2_r, f2_r, l2_r;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] mul_lo;
  logic              done_r;

  logic              out_valid_r;
  logic [DIM_W-1:0]  out_row_r, out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r, out_err_r;

  assign wr_addr = {in_row_index, in_col_index};

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= in_element_value;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem_a[cmd.addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= in_element_value;
    end
    if (cmd.rd_en) begin
      rd_b_r <= mem_b[cmd.addr_b];
    end
  end

  // low word of the product is all that survives the wrap
  assign mul_lo   = rd_a_r * rd_b_r;
  assign prod_nxt = s1_r ? (rd_a_r + rd_b_r) : mul_lo;
  assign acc_nxt  = f2_r ? prod_r : (acc_r + prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= cmd.rd_en;
      v2_r   <= v1_r;
      done_r <= v2_r && l2_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= cmd.first;
    l1_r <= cmd.last;
    s1_r <= cmd.is_sum;
    f2_r <= f1_r;
    l2_r <= l1_r;
    if (v1_r) begin
      prod_r <= prod_nxt;
    end
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_row_r   <= cmd.push_err ? '0 : cmd.row;
      out_col_r   <= cmd.push_err ? '0 : cmd.col;
      out_value_r <= cmd.push_err ? '0 : acc_r;
      out_last_r  <= cmd.push_err || cmd.fin;
      out_err_r   <= cmd.push_err;
    end
  end

  assign stat.acc_done = done_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_dim_error    = out_err_r;

  `IMAM_ASSERT_SAME(a_err_clean, out_valid_r && out_err_r, (out_value_r == '0) && out_last_r, "error result carries data")
  `IMAM_ASSERT_NEXT(a_done_after_last, v2_r && l2_r, done_r, "accumulator finish not flagged")

endmodule

// ----- src/imam_ctrl.sv -----
// ----------------------------------------------------------------------------
// imam_ctrl
// Command decode, size registers and element/term sequencing.
// ----------------------------------------------------------------------------
`include "integer_matrix_add_multiply_assert.svh"

module imam_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [imam_pkg::OP_W-1:0]      in_opcode,
  input  logic                           cfg_we,
  input  logic [imam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imam_pkg::CFG_W-1:0]     cfg_data,
  input  imam_pkg::dp_stat_t             stat,
  output imam_pkg::ctrl_cmd_t            cmd
);
  import imam_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_PUSH  = 5'b01000,
    ST_ERR   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic              sum_r, sum_nxt;
  logic [CFG_W-1:0]  rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [CNT_W-1:0]  ra, ca, rb, cb, len, ncols;
  logic              k_last, j_last, i_last, accept;

  // out-of-range sizes saturate at use
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign ra = eff_dim(rows_a_r);
  assign ca = eff_dim(cols_a_r);
  assign rb = eff_dim(rows_b_r);
  assign cb = eff_dim(cols_b_r);

  assign len    = sum_r ? CNT_W'(1) : ca;
  assign ncols  = sum_r ? ca : cb;
  assign k_last = ({1'b0, k_r} + CNT_W'(1)) == len;
  assign j_last = ({1'b0, j_r} + CNT_W'(1)) == ncols;
  assign i_last = ({1'b0, i_r} + CNT_W'(1)) == ra;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= CFG_W'(MAX_DIM);
      cols_a_r <= CFG_W'(MAX_DIM);
      rows_b_r <= CFG_W'(MAX_DIM);
      cols_b_r <= CFG_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A: rows_a_r <= cfg_data;
        CFG_COLS_A: cols_a_r <= cfg_data;
        CFG_ROWS_B: rows_b_r <= cfg_data;
        CFG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    sum_nxt      = sum_r;
    cmd          = '0;
    cmd.is_sum   = sum_r;
    cmd.row      = i_r;
    cmd.col      = j_r;
    cmd.addr_a   = {i_r, (sum_r ? j_r : k_r)};
    cmd.addr_b   = sum_r ? {i_r, j_r} : {k_r, j_r};
    cmd.first    = (k_r == '0);
    cmd.last     = k_last;
    cmd.fin      = i_last && j_last;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          case (in_opcode)
            OP_WR_A: cmd.wr_a = 1'b1;
            OP_WR_B: cmd.wr_b = 1'b1;
            OP_SUM: begin
              sum_nxt   = 1'b1;
              state_nxt = ((ra != rb) || (ca != cb)) ? ST_ERR : ST_ISSUE;
            end
            OP_PROD: begin
              sum_nxt   = 1'b0;
              state_nxt = (ca != rb) ? ST_ERR : ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stat.acc_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + DIM_W'(1);
            end else begin
              j_nxt = j_r + DIM_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      sum_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      sum_r   <= sum_nxt;
    end
  end

  `IMAM_ASSERT_SAME(a_push_free, cmd.push, stat.out_free, "request pushed into busy output")
  `IMAM_ASSERT_NEXT(a_issue_drain, (state_r == ST_ISSUE) && k_last, state_r == ST_DRAIN, "no drain after last term")
  `IMAM_ASSERT_SAME(a_done_in_drain, stat.acc_done, state_r == ST_DRAIN, "accumulator finished outside drain")

endmodule

// ----- src/integer_matrix_add_multiply.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_add_multiply
// Signed 32-bit matrix sum and product engine with element-wise loading.
// ----------------------------------------------------------------------------
// A write request is stored as it is accepted, leaving the block idle. A
// sum or product request is worked on alone: each result element takes n
// terms, n being 1 for a sum and the effective cols_a for a product, run
// one per cycle through the shared multiply/add unit and its two pipeline
// registers before the accumulator. A dimension mismatch answers with a
// single error result once the output register is free. The last result
// of a request sits in the output register while the next request is taken.
module integer_matrix_add_multiply (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [imam_pkg::OP_W-1:0]      in_opcode,
  input  logic [imam_pkg::DIM_W-1:0]     in_row_index,
  input  logic [imam_pkg::DIM_W-1:0]     in_col_index,
  input  logic signed [imam_pkg::DATA_W-1:0] in_element_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [imam_pkg::DIM_W-1:0]     out_row,
  output logic [imam_pkg::DIM_W-1:0]     out_col,
  output logic signed [imam_pkg::DATA_W-1:0] out_result_value,
  output logic                           out_last,
  output logic                           out_dim_error,
  input  logic                           cfg_we,
  input  logic [imam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imam_pkg::CFG_W-1:0]     cfg_data
);
  import imam_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  imam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  imam_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_dim_error    (out_dim_error)
  );

endmodule

// ----- sim/integer_matrix_add_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_add_multiply_tb
// Loads A and B element by element, issues sum and product requests under
// many dimension settings and checks every emitted element against an
// in-bench matrix predictor, with random gaps on the request side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module integer_matrix_add_multiply_tb;
  import imam_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_ITEMS    = 320;
  localparam int LIMIT_CYCLES  = 20_000_000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [DATA_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [DATA_W-1:0] val;
    logic              last;
    logic              err;
  } elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  req_t                     cur_req = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DIM_W-1:0]         out_row;
  logic [DIM_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_result_value;
  logic                     out_last;
  logic                     out_dim_error;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  // predictor state
  logic [DATA_W-1:0] mat_a [DEPTH];
  logic [DATA_W-1:0] mat_b [DEPTH];
  logic [CFG_W-1:0]  reg_rows_a = 4'd8;
  logic [CFG_W-1:0]  reg_cols_a = 4'd8;
  logic [CFG_W-1:0]  reg_rows_b = 4'd8;
  logic [CFG_W-1:0]  reg_cols_b = 4'd8;

  // stimulus side bookkeeping of which entries hold data
  bit loaded_a [DEPTH];
  bit loaded_b [DEPTH];

  req_t  request_q [$];
  elem_t expected_elems [$];

  logic        req_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          item_cnt = 0;
  int          elems_seen = 0;
  int          mismatch_cnt = 0;
  int unsigned cycle_count = 0;

  integer_matrix_add_multiply dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (cur_req.op),
    .in_row_index     (cur_req.row),
    .in_col_index     (cur_req.col),
    .in_element_value (cur_req.val),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_dim_error    (out_dim_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int eff_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_elem();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = 32'h0000_0000;
      4, 5: v = $urandom_range(0, 200) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly small sizes, now and then the full size
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return MAX_DIM;
    if (r < 20) return $urandom_range(5, MAX_DIM - 1);
    return $urandom_range(1, 4);
  endfunction

  // register bits for a wanted size, using the saturating encodings too
  function automatic logic [CFG_W-1:0] raw_of(int d);
    if (d == 1 && $urandom_range(0, 2) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(0, 1) == 1)
      return CFG_W'($urandom_range(MAX_DIM + 1, 15));
    return CFG_W'(d);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 100) $display("%0t mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_elem(int row, int col, logic [DATA_W-1:0] val, bit last, bit err);
    elem_t e;
    e.row = DIM_W'(row);
    e.col = DIM_W'(col);
    e.val = val;
    e.last = last;
    e.err = err;
    expected_elems.push_back(e);
  endtask

  // matrix engine behavior for one accepted request
  task automatic compute_elements(req_t r);
    int ra, ca, rb, cb;
    logic [DATA_W-1:0] acc;
    ra = eff_dim(reg_rows_a);
    ca = eff_dim(reg_cols_a);
    rb = eff_dim(reg_rows_b);
    cb = eff_dim(reg_cols_b);
    case (r.op)
      OP_WR_A: mat_a[{r.row, r.col}] = r.val;
      OP_WR_B: mat_b[{r.row, r.col}] = r.val;
      OP_SUM: begin
        if (ra != rb || ca != cb) begin
          push_elem(0, 0, '0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < ra; i++)
            for (int j = 0; j < ca; j++)
              push_elem(i, j, mat_a[i*MAX_DIM+j] + mat_b[i*MAX_DIM+j],
                        (i == ra - 1) && (j == ca - 1), 1'b0);
        end
      end
      default: begin
        if (ca != rb) begin
          push_elem(0, 0, '0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < ra; i++)
            for (int j = 0; j < cb; j++) begin
              acc = '0;
              for (int k = 0; k < ca; k++)
                acc = acc + mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
              push_elem(i, j, acc, (i == ra - 1) && (j == cb - 1), 1'b0);
            end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("element %0d %s got %0h want %0h",
                                elems_seen, name, got, want));
  endtask

  task automatic check_element();
    elem_t e;
    if (expected_elems.size() == 0) begin
      report_mismatch($sformatf("element %0d arrived with nothing pending", elems_seen));
    end else begin
      e = expected_elems.pop_front();
      check_field("row", out_row, e.row);
      check_field("col", out_col, e.col);
      check_field("value", out_result_value, e.val);
      check_field("last", out_last, e.last);
      check_field("dim_error", out_dim_error, e.err);
    end
    elems_seen++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (request_q.size() != 0) begin
        cur_req <= request_q.pop_front();
        in_valid <= 1'b1;
        send_gap = tx_idle_en ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = rx_idle_en ? pick_gap() : 0;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) compute_elements(cur_req);
      if (out_valid && !out_stall) check_element();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(logic [OP_W-1:0] op, logic [DIM_W-1:0] row,
                          logic [DIM_W-1:0] col, logic [DATA_W-1:0] val);
    req_t r;
    r.op = op;
    r.row = row;
    r.col = col;
    r.val = val;
    request_q.push_back(r);
    item_cnt++;
    if (op == OP_WR_A) loaded_a[{row, col}] = 1'b1;
    if (op == OP_WR_B) loaded_b[{row, col}] = 1'b1;
  endtask

  // command with junk in the fields it ignores
  task automatic push_cmd(logic [OP_W-1:0] op);
    push_req(op, DIM_W'($urandom), DIM_W'($urandom), rand_elem());
  endtask

  // load every unwritten entry of the region, refresh some written ones
  task automatic fill_region(logic [OP_W-1:0] op, int nr, int nc);
    int idx;
    bit seen;
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++) begin
        idx = i * MAX_DIM + j;
        seen = (op == OP_WR_A) ? loaded_a[idx] : loaded_b[idx];
        if (!seen || $urandom_range(0, 9) < 4)
          push_req(op, DIM_W'(i), DIM_W'(j), rand_elem());
      end
  endtask

  // wait for every request and result to clear, then let the block settle
  task automatic drain();
    while (request_q.size() != 0 || in_valid || expected_elems.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ROWS_A: reg_rows_a = val;
      CFG_COLS_A: reg_cols_a = val;
      CFG_ROWS_B: reg_rows_b = val;
      default:    reg_cols_b = val;
    endcase
  endtask

  task automatic program_dims(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                              logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
    write_reg(CFG_ROWS_A, ra);
    write_reg(CFG_COLS_A, ca);
    write_reg(CFG_ROWS_B, rb);
    write_reg(CFG_COLS_B, cb);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ra, ca, rb, cb, n_cmd, mode, rand_start;
    bit full, did_full;
    did_full = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 1x1 through zero-coded sizes: wrap on sum and product, min/max values
    program_dims(4'd0, 4'd1, 4'd1, 4'd0);
    push_req(OP_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
    push_req(OP_WR_B, 3'd0, 3'd0, 32'h0000_0001);
    push_cmd(OP_SUM);
    push_cmd(OP_PROD);
    push_req(OP_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    push_req(OP_WR_B, 3'd0, 3'd0, 32'h8000_0000);
    push_cmd(OP_SUM);
    push_cmd(OP_PROD);
    push_req(OP_WR_A, 3'd0, 3'd0, 32'hffff_ffff);
    push_req(OP_WR_B, 3'd0, 3'd0, 32'hffff_ffff);
    push_cmd(OP_SUM);
    push_cmd(OP_PROD);
    // far corner lies outside the configured size and stays unused
    push_req(OP_WR_A, 3'd7, 3'd7, 32'h8000_0000);
    push_req(OP_WR_B, 3'd7, 3'd7, 32'h7fff_ffff);
    push_req(OP_WR_A, 3'd0, 3'd0, 32'h0000_0000);
    push_req(OP_WR_B, 3'd0, 3'd0, 32'h0000_0000);
    push_cmd(OP_SUM);
    push_cmd(OP_PROD);
    drain();

    // saturating codes above the maximum, both commands mismatched
    program_dims(4'd9, 4'd2, 4'd1, 4'd15);
    push_cmd(OP_SUM);
    push_cmd(OP_PROD);
    drain();

    rand_start = item_cnt;
    while (item_cnt - rand_start < RAND_ITEMS) begin
      full = !did_full && (item_cnt - rand_start > 180);
      mode = $urandom_range(0, 4);
      ra = pick_dim();
      ca = pick_dim();
      if (mode < 2) begin
        rb = ra;
        cb = ca;
      end else if (mode < 4) begin
        rb = ca;
        cb = pick_dim();
      end else begin
        rb = pick_dim();
        cb = pick_dim();
      end
      if (full) begin
        ra = MAX_DIM;
        ca = MAX_DIM;
        rb = MAX_DIM;
        cb = MAX_DIM;
        did_full = 1'b1;
      end
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      program_dims(raw_of(ra), raw_of(ca), raw_of(rb), raw_of(cb));

      fill_region(OP_WR_A, ra, ca);
      fill_region(OP_WR_B, rb, cb);
      n_cmd = full ? 2 : $urandom_range(2, 8);
      repeat (n_cmd) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_cmd(OP_SUM);
          4, 5, 6, 7: push_cmd(OP_PROD);
          8:          push_req(OP_WR_A, DIM_W'($urandom), DIM_W'($urandom), rand_elem());
          default:    push_req(OP_WR_B, DIM_W'($urandom), DIM_W'($urandom), rand_elem());
        endcase
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/imam_pkg.sv
src/imam_dp.sv
src/imam_ctrl.sv
src/integer_matrix_add_multiply.sv
sim/integer_matrix_add_multiply_tb.sv
